/* rtl/bmmd_pkg.sv */
`default_nettype none

package bmmd_pkg;

    // Region codes reported with every result.
    localparam logic [3:0] REGION_ROM  = 4'd0;
    localparam logic [3:0] REGION_VRAM = 4'd1;
    localparam logic [3:0] REGION_CRAM = 4'd2;
    localparam logic [3:0] REGION_WRAM = 4'd3;
    localparam logic [3:0] REGION_OAM  = 4'd4;
    localparam logic [3:0] REGION_IO   = 4'd5;
    localparam logic [3:0] REGION_HRAM = 4'd6;
    localparam logic [3:0] REGION_IE   = 4'd7;
    localparam logic [3:0] REGION_NONE = 4'd8;
    localparam logic [3:0] REGION_BOOT = 4'd9;

    // Bank controller kinds.
    localparam logic [1:0] MBC_NONE = 2'd0;
    localparam logic [1:0] MBC_1    = 2'd1;
    localparam logic [1:0] MBC_2    = 2'd2;
    localparam logic [1:0] MBC_3    = 2'd3;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] CFG_MBC_KIND  = 2'd0;
    localparam logic [1:0] CFG_ROM_BANKS = 2'd1;
    localparam logic [1:0] CFG_BOOT_ROM  = 2'd2;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Bus access request.
    typedef struct packed {
        logic        func;
        logic [15:0] address;
        logic [7:0]  write_value;
    } bmmd_req_t;

    // Decoded access result.
    typedef struct packed {
        logic [3:0]  region;
        logic [20:0] offset;
        logic        store_enable;
        logic [7:0]  store_data;
        logic        open_bus;
        logic        save_dirty;
    } bmmd_rsp_t;

endpackage

`default_nettype wire

/* rtl/banked_memory_map_decoder.sv */
`default_nettype none

// Channel  Ports                          Dir  Contents
// s_       s_valid s_ready s_req          in   bus access: func, address, write_value
// m_       m_valid m_ready m_rsp          out  region, offset, store flags, open bus, dirty
// cfg      psel penable pwrite paddr ...  in   mbc_kind, rom_banks, boot_rom_present
//
// Each request is decoded in the cycle it is accepted and its result appears in the
// output register on the next cycle, so one request per cycle is sustained unless stalled.
// The banking registers update at the same edge the request is accepted, so the
// following request already sees the new bank selection.
// A stalled result holds in the output register; a new request is taken whenever the
// output register is empty or being drained. Reset is synchronous and active low.

module banked_memory_map_decoder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire bmmd_pkg::bmmd_req_t             s_req,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output bmmd_pkg::bmmd_rsp_t                  m_rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bmmd_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [bmmd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bmmd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    // Configuration registers.
    logic [1:0] mbc_kind_reg;
    logic [7:0] rom_banks_reg;
    logic       boot_rom_present_reg;

    // Banking state.
    logic [6:0] rom_bank_sel_reg,  rom_bank_sel_next;
    logic [7:0] ram_bank_sel_reg,  ram_bank_sel_next;
    logic       cart_ram_on_reg,   cart_ram_on_next;
    logic       banking_mode_reg,  banking_mode_next;
    logic       boot_overlay_reg,  boot_overlay_next;

    logic                 m_valid_reg;
    bmmd_pkg::bmmd_rsp_t  rsp_reg, rsp_next;

    logic        accept;
    logic        cfg_write;
    logic        wr;
    logic [15:0] a;
    logic [7:0]  v;
    logic        reach;
    logic        dirty;
    logic [7:0]  rom_bank_idx;
    logic [3:0]  region;
    logic [20:0] off;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign s_ready   = ~m_valid_reg | m_ready;
    assign accept    = s_valid & s_ready;
    assign m_valid   = m_valid_reg;
    assign m_rsp     = rsp_reg;

    assign wr = s_req.func;
    assign a  = s_req.address;
    assign v  = s_req.write_value;

    // Configuration read-back.
    always_comb begin
        unique case (paddr[3:2])
            bmmd_pkg::CFG_MBC_KIND:  prdata = {30'd0, mbc_kind_reg};
            bmmd_pkg::CFG_ROM_BANKS: prdata = {24'd0, rom_banks_reg};
            bmmd_pkg::CFG_BOOT_ROM:  prdata = {31'd0, boot_rom_present_reg};
            default:                 prdata = '0;
        endcase
    end

    // ROM bank that a read falls into: bank 0 below 0x4000, else the switchable bank.
    assign rom_bank_idx = (a[15:14] == 2'b00) ? 8'd0 : {1'b0, rom_bank_sel_reg};

    // Address decode and banking register updates.
    always_comb begin
        region            = bmmd_pkg::REGION_NONE;
        off               = '0;
        reach             = 1'b1;
        dirty             = 1'b0;
        rom_bank_sel_next = rom_bank_sel_reg;
        ram_bank_sel_next = ram_bank_sel_reg;
        cart_ram_on_next  = cart_ram_on_reg;
        banking_mode_next = banking_mode_reg;
        boot_overlay_next = boot_overlay_reg;

        if (!wr && a < 16'h0100 && boot_overlay_reg && boot_rom_present_reg) begin
            region = bmmd_pkg::REGION_BOOT;
            off    = {13'd0, a[7:0]};
        end else if (a <= 16'h7FFF) begin
            region = bmmd_pkg::REGION_ROM;
            if (wr) begin
                reach = 1'b0;
                unique case (mbc_kind_reg)
                    bmmd_pkg::MBC_1: begin
                        if (a <= 16'h1FFF) begin
                            cart_ram_on_next = (v[3:0] == 4'hA);
                        end else if (a <= 16'h3FFF) begin
                            rom_bank_sel_next = (v[4:0] == 5'd0) ? 7'd1 : {2'd0, v[4:0]};
                        end else if (a <= 16'h5FFF) begin
                            if (banking_mode_reg) begin
                                ram_bank_sel_next = {6'd0, v[1:0]};
                            end
                        end else begin
                            banking_mode_next = v[0];
                        end
                    end
                    bmmd_pkg::MBC_2: begin
                        if (a <= 16'h3FFF) begin
                            if (!a[8]) begin
                                cart_ram_on_next = (v[3:0] == 4'hA);
                            end else begin
                                rom_bank_sel_next = (v[3:0] == 4'd0) ? 7'd1 : {3'd0, v[3:0]};
                            end
                        end
                    end
                    bmmd_pkg::MBC_3: begin
                        if (a <= 16'h1FFF) begin
                            cart_ram_on_next = (v[3:0] == 4'hA);
                        end else if (a <= 16'h3FFF) begin
                            rom_bank_sel_next = (v[6:0] == 7'd0) ? 7'd1 : v[6:0];
                        end else if (a <= 16'h5FFF) begin
                            ram_bank_sel_next = v;
                        end
                    end
                    default: begin
                        // No controller: writes have no effect.
                    end
                endcase
            end else begin
                // The read lies beyond the ROM exactly when its bank is not below the size.
                reach = (rom_bank_idx < rom_banks_reg);
                off   = {rom_bank_idx[6:0], a[13:0]};
            end
        end else if (a <= 16'h9FFF) begin
            region = bmmd_pkg::REGION_VRAM;
            off    = {8'd0, a[12:0]};
        end else if (a <= 16'hBFFF) begin
            region = bmmd_pkg::REGION_CRAM;
            if (!cart_ram_on_reg) begin
                reach = 1'b0;
            end else if (mbc_kind_reg == bmmd_pkg::MBC_3) begin
                if (ram_bank_sel_reg <= 8'd3) begin
                    off = {6'd0, ram_bank_sel_reg[1:0], a[12:0]};
                end else begin
                    reach = 1'b0;
                end
            end else begin
                off = {8'd0, a[12:0]};
            end
            dirty = reach & wr;
        end else if (a <= 16'hDFFF) begin
            region = bmmd_pkg::REGION_WRAM;
            off    = {8'd0, a[12:0]};
        end else if (a <= 16'hFDFF) begin
            // Echo area folds onto work RAM.
            region = bmmd_pkg::REGION_WRAM;
            off    = {8'd0, a[12:0]};
        end else if (a <= 16'hFE9F) begin
            region = bmmd_pkg::REGION_OAM;
            off    = {13'd0, a[7:0]};
        end else if (a <= 16'hFEFF) begin
            region = bmmd_pkg::REGION_NONE;
            reach  = 1'b0;
        end else if (a <= 16'hFF7F) begin
            region = bmmd_pkg::REGION_IO;
            off    = {13'd0, a[7:0]};
            if (wr && a == 16'hFF50) begin
                boot_overlay_next = 1'b0;
            end
        end else if (a <= 16'hFFFE) begin
            region = bmmd_pkg::REGION_HRAM;
            off    = {13'd0, a[7:0] - 8'h80};
        end else begin
            region = bmmd_pkg::REGION_IE;
        end
    end

    // Result assembly.
    always_comb begin
        rsp_next.region       = region;
        rsp_next.offset       = reach ? off : 21'd0;
        rsp_next.store_enable = wr & reach;
        rsp_next.store_data   = (wr && reach) ? v : 8'd0;
        rsp_next.open_bus     = ~wr & ~reach;
        rsp_next.save_dirty   = dirty;
    end

    // Configuration and banking state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbc_kind_reg         <= bmmd_pkg::MBC_NONE;
            rom_banks_reg        <= '0;
            boot_rom_present_reg <= 1'b0;
            rom_bank_sel_reg     <= 7'd1;
            ram_bank_sel_reg     <= '0;
            cart_ram_on_reg      <= 1'b0;
            banking_mode_reg     <= 1'b0;
            boot_overlay_reg     <= 1'b1;
        end else begin
            if (cfg_write) begin
                unique case (paddr[3:2])
                    bmmd_pkg::CFG_MBC_KIND:  mbc_kind_reg         <= pwdata[1:0];
                    bmmd_pkg::CFG_ROM_BANKS: rom_banks_reg        <= pwdata[7:0];
                    bmmd_pkg::CFG_BOOT_ROM:  boot_rom_present_reg <= pwdata[0];
                    default: begin
                        // Unmapped address: write is dropped.
                    end
                endcase
            end
            if (accept) begin
                rom_bank_sel_reg <= rom_bank_sel_next;
                ram_bank_sel_reg <= ram_bank_sel_next;
                cart_ram_on_reg  <= cart_ram_on_next;
                banking_mode_reg <= banking_mode_next;
                boot_overlay_reg <= boot_overlay_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/bmmd_checker.sv */
`default_nettype none

module bmmd_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire bmmd_pkg::bmmd_req_t             s_req,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire bmmd_pkg::bmmd_rsp_t             m_rsp
);

    // Every accepted request shows its result on the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request did not produce a result");

    // A read never stores and never marks save data dirty.
    a_read_no_store: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_req.func |=> !m_rsp.store_enable && !m_rsp.save_dirty)
        else $error("read request produced a store");

    // A write never reports an open-bus read.
    a_write_no_open_bus: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req.func |=> !m_rsp.open_bus)
        else $error("write request reported open bus");

    // A stalled result holds its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("stalled result changed");

endmodule

bind banked_memory_map_decoder bmmd_checker u_bmmd_checker (.*);

`default_nettype wire

/* tb/tb_banked_memory_map_decoder.sv */
module tb_banked_memory_map_decoder;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [15:0] BOOT_OFF_ADDR = 16'hFF50;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          PHASE_ITEMS   = 220;

    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    bmmd_pkg::bmmd_req_t             s_req   = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    bmmd_pkg::bmmd_rsp_t             m_rsp;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [bmmd_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [bmmd_pkg::CFG_DATA_W-1:0] pwdata  = '0;
    logic [bmmd_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    // Configuration and banking state as the decoder should hold it.
    logic [1:0] cfg_kind      = bmmd_pkg::MBC_NONE;
    logic [7:0] cfg_rom_banks = 8'd0;
    logic       cfg_boot_rom  = 1'b0;
    logic [6:0] rom_bank_q    = 7'd1;
    logic [7:0] ram_bank_q    = 8'd0;
    logic       cram_on_q     = 1'b0;
    logic       bank_mode_q   = 1'b0;
    logic       overlay_on_q  = 1'b1;

    bmmd_pkg::bmmd_rsp_t pending_decodes[$];
    int        access_cnt   = 0;
    int        mismatch_cnt = 0;
    int        gap_pct      = 0;
    int        stall_pct    = 0;
    int        quiet_cycles = 0;

    banked_memory_map_decoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The result side stalls at random according to the current phase.
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= stall_pct);
    end

    // Decode one accepted bus access and update the banking state it touches.
    task automatic decode_access(input bmmd_pkg::bmmd_req_t r, output bmmd_pkg::bmmd_rsp_t e);
        int unsigned a, v, off, phys, size, bank, sel;
        logic        wr, reach, dirty;
        logic [3:0]  region;
        a      = 32'(r.address);
        v      = 32'(r.write_value);
        wr     = r.func;
        off    = 0;
        reach  = 1'b1;
        dirty  = 1'b0;
        region = bmmd_pkg::REGION_NONE;
        if (wr == FUNC_READ && a < 'h100 && overlay_on_q && cfg_boot_rom) begin
            region = bmmd_pkg::REGION_BOOT;
            off    = a;
        end else if (a <= 'h7FFF) begin
            region = bmmd_pkg::REGION_ROM;
            if (wr == FUNC_WRITE) begin
                reach = 1'b0;
                // Bank controller register writes.
                case (cfg_kind)
                    bmmd_pkg::MBC_1: begin
                        if (a <= 'h1FFF) begin
                            cram_on_q = ((v & 'h0F) == 'h0A);
                        end else if (a <= 'h3FFF) begin
                            sel = v & 'h1F;
                            rom_bank_q = (sel == 0) ? 7'd1 : sel[6:0];
                        end else if (a <= 'h5FFF) begin
                            if (bank_mode_q) ram_bank_q = 8'(v & 'h03);
                        end else begin
                            bank_mode_q = v[0];
                        end
                    end
                    bmmd_pkg::MBC_2: begin
                        if (a <= 'h3FFF) begin
                            if ((a & 'h100) == 0) begin
                                cram_on_q = ((v & 'h0F) == 'h0A);
                            end else begin
                                sel = v & 'h0F;
                                rom_bank_q = (sel == 0) ? 7'd1 : sel[6:0];
                            end
                        end
                    end
                    bmmd_pkg::MBC_3: begin
                        if (a <= 'h1FFF) begin
                            cram_on_q = ((v & 'h0F) == 'h0A);
                        end else if (a <= 'h3FFF) begin
                            sel = v & 'h7F;
                            rom_bank_q = (sel == 0) ? 7'd1 : sel[6:0];
                        end else if (a <= 'h5FFF) begin
                            ram_bank_q = v[7:0];
                        end
                    end
                    default: ;
                endcase
            end else begin
                // Bank 0 is fixed; the upper window follows the selected bank.
                bank = 32'(rom_bank_q);
                size = 32'(cfg_rom_banks) * 'h4000;
                phys = (a <= 'h3FFF) ? a : bank * 'h4000 + (a - 'h4000);
                if (cfg_rom_banks == 0 || phys >= size) reach = 1'b0;
                else off = phys;
            end
        end else if (a <= 'h9FFF) begin
            region = bmmd_pkg::REGION_VRAM;
            off    = a - 'h8000;
        end else if (a <= 'hBFFF) begin
            region = bmmd_pkg::REGION_CRAM;
            if (!cram_on_q) begin
                reach = 1'b0;
            end else if (cfg_kind == bmmd_pkg::MBC_3) begin
                // Selections above 3 address the clock registers.
                if (ram_bank_q <= 8'd3) off = 32'(ram_bank_q) * 'h2000 + (a - 'hA000);
                else reach = 1'b0;
            end else begin
                off = a - 'hA000;
            end
            if (reach && wr == FUNC_WRITE) dirty = 1'b1;
        end else if (a <= 'hDFFF) begin
            region = bmmd_pkg::REGION_WRAM;
            off    = a - 'hC000;
        end else if (a <= 'hFDFF) begin
            region = bmmd_pkg::REGION_WRAM;
            off    = a - 'hE000;
        end else if (a <= 'hFE9F) begin
            region = bmmd_pkg::REGION_OAM;
            off    = a - 'hFE00;
        end else if (a <= 'hFEFF) begin
            region = bmmd_pkg::REGION_NONE;
            reach  = 1'b0;
        end else if (a <= 'hFF7F) begin
            region = bmmd_pkg::REGION_IO;
            off    = a - 'hFF00;
            if (wr == FUNC_WRITE && a == 32'(BOOT_OFF_ADDR)) overlay_on_q = 1'b0;
        end else if (a <= 'hFFFE) begin
            region = bmmd_pkg::REGION_HRAM;
            off    = a - 'hFF80;
        end else begin
            region = bmmd_pkg::REGION_IE;
        end
        e.region       = region;
        e.offset       = reach ? off[20:0] : 21'd0;
        e.store_enable = (wr == FUNC_WRITE) && reach;
        e.store_data   = ((wr == FUNC_WRITE) && reach) ? v[7:0] : 8'd0;
        e.open_bus     = (wr == FUNC_READ) && !reach;
        e.save_dirty   = dirty;
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_cnt++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Compare every result with the oldest outstanding decode.
    always @(posedge aclk) begin : check_results
        bmmd_pkg::bmmd_rsp_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_decodes.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: unexpected result, expected none, got 0x%0h", $time, m_rsp);
            end else begin
                want = pending_decodes.pop_front();
                if (m_rsp.region !== want.region)
                    report_mismatch("region", 32'(want.region), 32'(m_rsp.region));
                if (m_rsp.offset !== want.offset)
                    report_mismatch("offset", 32'(want.offset), 32'(m_rsp.offset));
                if (m_rsp.store_enable !== want.store_enable)
                    report_mismatch("store_enable", 32'(want.store_enable),
                                    32'(m_rsp.store_enable));
                if (m_rsp.store_data !== want.store_data)
                    report_mismatch("store_data", 32'(want.store_data),
                                    32'(m_rsp.store_data));
                if (m_rsp.open_bus !== want.open_bus)
                    report_mismatch("open_bus", 32'(want.open_bus), 32'(m_rsp.open_bus));
                if (m_rsp.save_dirty !== want.save_dirty)
                    report_mismatch("save_dirty", 32'(want.save_dirty),
                                    32'(m_rsp.save_dirty));
            end
        end
    end

    // End the run if nothing moves on any port for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready) ||
            (psel && penable && pready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Send one request, with a random idle gap ahead of it. Starts and ends at a falling edge.
    task automatic send_access(input logic f, input logic [15:0] addr, input logic [7:0] val);
        int                  gap;
        bmmd_pkg::bmmd_req_t r;
        bmmd_pkg::bmmd_rsp_t e;
        gap = 0;
        while (gap < 200 && $urandom_range(99) < gap_pct) gap++;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        r.func        = f;
        r.address     = addr;
        r.write_value = val;
        s_req   = r;
        s_valid = 1'b1;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        decode_access(r, e);
        pending_decodes.push_back(e);
        access_cnt++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_decodes.size() != 0) @(negedge aclk);
    endtask

    // Write one configuration register, then read it back.
    task automatic cfg_write(input logic [1:0] idx,
                             input logic [bmmd_pkg::CFG_DATA_W-1:0] val);
        logic [bmmd_pkg::CFG_DATA_W-1:0] rd, want;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (pready !== 1'b1) @(posedge aclk);
        case (idx)
            bmmd_pkg::CFG_MBC_KIND: begin
                cfg_kind = val[1:0];
                want = {30'd0, val[1:0]};
            end
            bmmd_pkg::CFG_ROM_BANKS: begin
                cfg_rom_banks = val[7:0];
                want = {24'd0, val[7:0]};
            end
            default: begin
                cfg_boot_rom = val[0];
                want = {31'd0, val[0]};
            end
        endcase
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (pready !== 1'b1) @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd !== want) begin
            mismatch_cnt++;
            $display("%0t: register %0d readback mismatch, expected 0x%0h, got 0x%0h",
                     $time, idx, want, rd);
        end
    endtask

    task automatic apply_setting(input logic [1:0] kind, input logic [7:0] banks,
                                 input logic boot);
        wait_idle();
        cfg_write(bmmd_pkg::CFG_MBC_KIND, 32'(kind));
        cfg_write(bmmd_pkg::CFG_ROM_BANKS, 32'(banks));
        cfg_write(bmmd_pkg::CFG_BOOT_ROM, 32'(boot));
    endtask

    // Controller data that hits the interesting encodings often.
    function automatic logic [7:0] ctrl_value();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return {4'($urandom), 4'hA};
            2:       return 8'($urandom_range(7));
            default: return 8'($urandom);
        endcase
    endfunction

    // Boot overlay covers the low page for reads until 0xFF50 is written.
    task automatic test_boot_overlay();
        gap_pct   = 0;
        stall_pct = 0;
        apply_setting(bmmd_pkg::MBC_NONE, 8'd0, 1'b1);
        send_access(FUNC_READ, 16'h0000, 8'hFF);
        send_access(FUNC_READ, 16'h00FF, 8'h00);
        send_access(FUNC_WRITE, 16'h0000, 8'hFF);
        send_access(FUNC_READ, 16'h0100, 8'h00);
        send_access(FUNC_WRITE, BOOT_OFF_ADDR, 8'h01);
        send_access(FUNC_READ, 16'h0000, 8'h00);
    endtask

    // MBC3 bank selection at its extremes, including the clock register select.
    task automatic test_bank_controller();
        apply_setting(bmmd_pkg::MBC_3, 8'd128, 1'b0);
        send_access(FUNC_WRITE, 16'h0000, 8'h0A);
        send_access(FUNC_WRITE, 16'h2000, 8'h00);
        send_access(FUNC_READ, 16'h7FFF, 8'h00);
        send_access(FUNC_WRITE, 16'h3FFF, 8'hFF);
        send_access(FUNC_READ, 16'h7FFF, 8'hFF);
        send_access(FUNC_WRITE, 16'h4000, 8'h03);
        send_access(FUNC_WRITE, 16'hBFFF, 8'hA5);
        send_access(FUNC_WRITE, 16'h5FFF, 8'h08);
        send_access(FUNC_READ, 16'hA000, 8'h00);
    endtask

    // Region boundaries, echo, and the unusable area.
    task automatic test_memory_map();
        send_access(FUNC_READ, 16'h8000, 8'h00);
        send_access(FUNC_WRITE, 16'h9FFF, 8'hFF);
        send_access(FUNC_READ, 16'hE000, 8'h00);
        send_access(FUNC_WRITE, 16'hFDFF, 8'h5A);
        send_access(FUNC_READ, 16'hFE9F, 8'h00);
        send_access(FUNC_READ, 16'hFEA0, 8'h00);
        send_access(FUNC_WRITE, 16'hFEFF, 8'hC3);
        send_access(FUNC_WRITE, 16'hFF7F, 8'h81);
        send_access(FUNC_READ, 16'hFF80, 8'h00);
        send_access(FUNC_WRITE, 16'hFFFF, 8'h1F);
    endtask

    // Enable RAM, pick banks, then touch the banked windows.
    task automatic banking_sequence();
        logic [15:0] en_addr, rom_addr;
        int          n;
        if (cfg_kind == bmmd_pkg::MBC_2) begin
            en_addr  = 16'($urandom_range('h3FFF)) & 16'hFEFF;
            rom_addr = 16'($urandom_range('h3FFF)) | 16'h0100;
        end else begin
            en_addr  = 16'($urandom_range('h1FFF));
            rom_addr = 16'($urandom_range('h3FFF, 'h2000));
        end
        send_access(FUNC_WRITE, en_addr,
                    ($urandom_range(9) == 0) ? 8'($urandom) : {4'($urandom), 4'hA});
        send_access(FUNC_WRITE, rom_addr, ctrl_value());
        if (cfg_kind == bmmd_pkg::MBC_1)
            send_access(FUNC_WRITE, 16'($urandom_range('h7FFF, 'h6000)), 8'($urandom));
        if (cfg_kind != bmmd_pkg::MBC_2)
            send_access(FUNC_WRITE, 16'($urandom_range('h5FFF, 'h4000)),
                        ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
        n = $urandom_range(6, 2);
        repeat (n) begin
            if ($urandom_range(1))
                send_access(FUNC_READ, 16'($urandom_range('h7FFF, 'h4000)), 8'($urandom));
            else
                send_access(1'($urandom), 16'($urandom_range('hBFFF, 'hA000)), 8'($urandom));
        end
    endtask

    task automatic random_access();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            send_access(FUNC_WRITE, 16'($urandom_range('h7FFF)), ctrl_value());
        else if (pick < 45)
            send_access(FUNC_READ, 16'($urandom_range('h7FFF)), 8'($urandom));
        else if (pick < 65)
            send_access(1'($urandom), 16'($urandom_range('hBFFF, 'hA000)), 8'($urandom));
        else if (pick < 72)
            send_access(1'($urandom), 16'($urandom_range('hFEFF, 'hFE00)), 8'($urandom));
        else if (pick < 80)
            send_access(1'($urandom), 16'($urandom_range('hFFFF, 'hFF00)), 8'($urandom));
        else
            send_access(1'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Random traffic over several controller settings and idle patterns.
    task automatic test_random_traffic();
        int target;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: apply_setting(bmmd_pkg::MBC_1, 8'd128, 1'b1);
                1: apply_setting(bmmd_pkg::MBC_2, 8'd16, 1'b0);
                2: apply_setting(bmmd_pkg::MBC_3, 8'd128, 1'b1);
                3: apply_setting(bmmd_pkg::MBC_NONE, 8'd2, 1'b0);
                4: apply_setting(bmmd_pkg::MBC_3, 8'd0, 1'b1);
                5: apply_setting(bmmd_pkg::MBC_1, 8'($urandom_range(128, 1)), 1'b0);
                6: apply_setting(bmmd_pkg::MBC_2, 8'd1, 1'b1);
                default: apply_setting(bmmd_pkg::MBC_3, 8'($urandom_range(128, 1)), 1'b0);
            endcase
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 83; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 83; end
                default: begin gap_pct = 8; stall_pct = 8; end
            endcase
            target = access_cnt + PHASE_ITEMS;
            while (access_cnt < target) begin
                if ($urandom_range(1)) banking_sequence();
                else random_access();
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        test_boot_overlay();
        test_bank_controller();
        test_memory_map();
        test_random_traffic();
        wait_idle();
        repeat (5) @(negedge aclk);
        if (mismatch_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
